@@ rtl/alil_pkg.sv @@
// Package for the array list block: sizes, request opcodes and result status codes.
// Used by the top level and the checker; has no dependencies.
`timescale 1ns / 1ps

package alil_pkg;

    localparam int CAPACITY    = 128;
    localparam int OPCODE_W    = 3;
    localparam int VALUE_W     = 32;
    localparam int INDEX_W     = 8;
    localparam int STATUS_W    = 3;
    localparam int COUNT_NOW_W = 8;

    // Storage address and count widths; the count must be able to hold CAPACITY itself
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    // Width in which an index and the count are compared
    localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    localparam logic [OPCODE_W-1:0] OP_APPEND  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_INSERT  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_REM_VAL = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_REM_IDX = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_READ    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

endpackage

@@ rtl/array_list_insert_remove_top.sv @@
// Array list with shifting insert and removal: one request in, one result out.
// Channels: in_valid/in_ready carry opcode, value and index; out_valid/out_ready carry
// status, read_value and count_now. One request is worked on at a time.
// The entries live in one RAM with a registered read port; every shift step reads one
// entry and writes its neighbour, one read and one write per cycle.
// Append, a rejected request and an unknown opcode go straight to the result; a read
// first waits for the registered RAM data. Insert at an index i below the count shifts
// the entries from i upward (at i equal to the count it writes directly); remove at index
// i shifts those above i downward (none when i is the last entry); remove by value scans
// from index 0 for the first match and closes the gap from there, or reports not found.
// in_ready is high only while no request is in progress; a finished result waits in the
// output register, and the next request may be accepted meanwhile. If the receiver
// stalls, the block holds a later result until the output register frees.
// Reset clears the count, so the list is empty; the RAM needs no clearing pass.
// Depends on alil_pkg and alil_ram.
`timescale 1ns / 1ps

module array_list_insert_remove_top (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic        [alil_pkg::OPCODE_W-1:0]    opcode,
    input  logic signed [alil_pkg::VALUE_W-1:0]     value,
    input  logic        [alil_pkg::INDEX_W-1:0]     index,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic        [alil_pkg::STATUS_W-1:0]    status,
    output logic signed [alil_pkg::VALUE_W-1:0]     read_value,
    output logic        [alil_pkg::COUNT_NOW_W-1:0] count_now
);

    import alil_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_DOWN,
        S_SCAN,
        S_RD_WAIT,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [VALUE_W-1:0]  val_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic                pend_reg;
    logic [ADDR_W-1:0]   pend_addr_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [VALUE_W-1:0]  res_value_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [VALUE_W-1:0]  read_value_reg;
    logic [COUNT_NOW_W-1:0] count_now_reg;

    logic [CMP_W-1:0]    idx_ext;
    logic [CMP_W-1:0]    cnt_ext;
    logic                full;
    logic                empty;
    logic                idx_gt;
    logic                idx_ge;
    logic                match;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [VALUE_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [VALUE_W-1:0]  ram_rdata;

    alil_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY),
        .ADDR_W(ADDR_W)
    ) u_entries (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign idx_ext = CMP_W'(index);
    assign cnt_ext = CMP_W'(count_reg);
    assign full    = cnt_ext >= CMP_W'(CAPACITY);
    assign empty   = (count_reg == '0);
    assign idx_gt  = idx_ext > cnt_ext;
    assign idx_ge  = idx_ext >= cnt_ext;
    assign match   = (ram_rdata == val_reg);

    // RAM port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == OP_APPEND && !full)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = count_reg[ADDR_W-1:0];
                        ram_wdata = value;
                    end
                    if (opcode == OP_INSERT && !full && idx_ext == cnt_ext)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = idx_ext[ADDR_W-1:0];
                        ram_wdata = value;
                    end
                    if (opcode == OP_READ && !empty && !idx_ge)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_ext[ADDR_W-1:0];
                    end
                end
            end
            S_UP:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg + 1'b1;
                    ram_wdata = ram_rdata;
                end
                else if (rem_reg == '0)
                begin
                    // drop the new value into the gap
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg[ADDR_W-1:0];
                    ram_wdata = val_reg;
                end
                if (rem_reg != '0)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = rd_ptr_reg[ADDR_W-1:0];
                end
            end
            S_DOWN:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg - 1'b1;
                    ram_wdata = ram_rdata;
                end
                if (rem_reg != '0)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = rd_ptr_reg[ADDR_W-1:0];
                end
            end
            S_SCAN:
            begin
                if (rem_reg != '0 && !(pend_reg && match))
                begin
                    ram_re    = 1'b1;
                    ram_raddr = rd_ptr_reg[ADDR_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            val_reg        <= '0;
            idx_reg        <= '0;
            rd_ptr_reg     <= '0;
            rem_reg        <= '0;
            pend_reg       <= 1'b0;
            pend_addr_reg  <= '0;
            res_status_reg <= ST_OK;
            res_value_reg  <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= ST_OK;
            read_value_reg <= '0;
            count_now_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        val_reg        <= value;
                        res_value_reg  <= '0;
                        res_status_reg <= ST_OK;
                        pend_reg       <= 1'b0;
                        state_reg      <= S_DONE;
                        unique case (opcode)
                            OP_APPEND:
                            begin
                                if (full)
                                begin
                                    res_status_reg <= ST_FULL;
                                end
                                else
                                begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            OP_INSERT:
                            begin
                                if (full)
                                begin
                                    res_status_reg <= ST_FULL;
                                end
                                else if (idx_gt)
                                begin
                                    res_status_reg <= ST_BAD_INDEX;
                                end
                                else if (idx_ext == cnt_ext)
                                begin
                                    count_reg <= count_reg + 1'b1;
                                end
                                else
                                begin
                                    idx_reg    <= CNT_W'(idx_ext);
                                    rd_ptr_reg <= count_reg - 1'b1;
                                    rem_reg    <= CNT_W'(cnt_ext - idx_ext);
                                    state_reg  <= S_UP;
                                end
                            end
                            OP_REM_VAL:
                            begin
                                if (empty)
                                begin
                                    res_status_reg <= ST_EMPTY;
                                end
                                else
                                begin
                                    rd_ptr_reg <= '0;
                                    rem_reg    <= count_reg;
                                    state_reg  <= S_SCAN;
                                end
                            end
                            OP_REM_IDX:
                            begin
                                if (empty)
                                begin
                                    res_status_reg <= ST_EMPTY;
                                end
                                else if (idx_ge)
                                begin
                                    res_status_reg <= ST_BAD_INDEX;
                                end
                                else
                                begin
                                    rd_ptr_reg <= CNT_W'(idx_ext) + 1'b1;
                                    rem_reg    <= CNT_W'(cnt_ext - idx_ext) - 1'b1;
                                    state_reg  <= S_DOWN;
                                end
                            end
                            OP_READ:
                            begin
                                if (empty)
                                begin
                                    res_status_reg <= ST_EMPTY;
                                end
                                else if (idx_ge)
                                begin
                                    res_status_reg <= ST_BAD_INDEX;
                                end
                                else
                                begin
                                    state_reg <= S_RD_WAIT;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_UP:
                begin
                    // walk downwards: read entry p, then write the registered read data to p + 1
                    if (rem_reg != '0)
                    begin
                        rd_ptr_reg    <= rd_ptr_reg - 1'b1;
                        rem_reg       <= rem_reg - 1'b1;
                        pend_reg      <= 1'b1;
                        pend_addr_reg <= rd_ptr_reg[ADDR_W-1:0];
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                    if (rem_reg == '0 && !pend_reg)
                    begin
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_DONE;
                    end
                end
                S_DOWN:
                begin
                    // walk upwards: read entry p, then write the registered read data to p - 1
                    if (rem_reg != '0)
                    begin
                        rd_ptr_reg    <= rd_ptr_reg + 1'b1;
                        rem_reg       <= rem_reg - 1'b1;
                        pend_reg      <= 1'b1;
                        pend_addr_reg <= rd_ptr_reg[ADDR_W-1:0];
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                    if (rem_reg == '0 && !pend_reg)
                    begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_DONE;
                    end
                end
                S_SCAN:
                begin
                    if (pend_reg && match)
                    begin
                        // first match found: close the gap from there
                        rd_ptr_reg <= CNT_W'(pend_addr_reg) + 1'b1;
                        rem_reg    <= count_reg - 1'b1 - CNT_W'(pend_addr_reg);
                        pend_reg   <= 1'b0;
                        state_reg  <= S_DOWN;
                    end
                    else if (rem_reg == '0 && !pend_reg)
                    begin
                        res_status_reg <= ST_NOT_FOUND;
                        state_reg      <= S_DONE;
                    end
                    else if (rem_reg != '0)
                    begin
                        rd_ptr_reg    <= rd_ptr_reg + 1'b1;
                        rem_reg       <= rem_reg - 1'b1;
                        pend_reg      <= 1'b1;
                        pend_addr_reg <= rd_ptr_reg[ADDR_W-1:0];
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                end
                S_RD_WAIT:
                begin
                    res_value_reg <= ram_rdata;
                    state_reg     <= S_DONE;
                end
                S_DONE:
                begin
                    // hold the result until the output register frees
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        status_reg     <= res_status_reg;
                        read_value_reg <= res_value_reg;
                        count_now_reg  <= cnt_ext[COUNT_NOW_W-1:0];
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;
    assign count_now  = count_now_reg;

endmodule

@@ rtl/alil_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module alil_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/alil_checker.sv @@
// Port-level checker for the array list top level, with the bind that attaches it.
// Depends on alil_pkg and array_list_insert_remove_top.
`timescale 1ns / 1ps

module alil_checker (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    in_valid,
    input logic                                    in_ready,
    input logic        [alil_pkg::OPCODE_W-1:0]    opcode,
    input logic signed [alil_pkg::VALUE_W-1:0]     value,
    input logic        [alil_pkg::INDEX_W-1:0]     index,
    input logic                                    out_valid,
    input logic                                    out_ready,
    input logic        [alil_pkg::STATUS_W-1:0]    status,
    input logic signed [alil_pkg::VALUE_W-1:0]     read_value,
    input logic        [alil_pkg::COUNT_NOW_W-1:0] count_now
);

    import alil_pkg::*;

    localparam logic [COUNT_NOW_W-1:0] CAP_LOW = COUNT_NOW_W'(CAPACITY);

    // one request at a time: no acceptance in the cycle after one
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while another was in progress");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status)
            && $stable(read_value) && $stable(count_now)))
        else $error("result changed while stalled");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (read_value == '0))
        else $error("non-zero read value on a rejected request");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> (count_now == CAP_LOW))
        else $error("full status with the list not full");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_EMPTY) |-> (count_now == '0))
        else $error("empty status with entries present");

endmodule

bind array_list_insert_remove_top alil_checker u_alil_checker (.*);

@@ verif/tb_array_list_insert_remove_top.sv @@
// Self-checking testbench for array_list_insert_remove_top: a directed table, then random
// grow/shrink traffic; each result is checked against the table's expected result or a local model of the list.
// Depends on alil_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module tb_array_list_insert_remove_top;
    import alil_pkg::*;

    localparam int RANDOM_ITEMS = 1560;
    localparam int HOLD_AT      = 700;
    localparam int HOLD_CYCLES  = 600;
    localparam int PAUSE_AT     = 1000;
    localparam int QUIET_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 40;
    localparam int PRINT_CAP    = 40;

    // opcodes the block must ignore
    localparam logic [OPCODE_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] read_value;
        logic [COUNT_NOW_W-1:0]    count_now;
    } list_result_t;

    typedef struct packed {
        logic [OPCODE_W-1:0]       op;
        logic signed [VALUE_W-1:0] val;
        logic [INDEX_W-1:0]        idx;
        logic                      typed;
        list_result_t              want;
    } list_request_t;

    localparam int N_DIRECTED = 25;
    localparam list_request_t DIRECTED [N_DIRECTED] = '{
        '{OP_READ,    32'sd0,              8'd0,   1'b1, '{ST_EMPTY,     32'sd0, 8'd0}},
        '{OP_REM_IDX, 32'sd0,              8'd0,   1'b1, '{ST_EMPTY,     32'sd0, 8'd0}},
        '{OP_REM_VAL, 32'sd0,              8'd0,   1'b1, '{ST_EMPTY,     32'sd0, 8'd0}},
        '{OP_INSERT,  32'sd7,              8'd1,   1'b1, '{ST_BAD_INDEX, 32'sd0, 8'd0}},
        '{OP_INSERT,  32'sh8000_0000,      8'd0,   1'b1, '{ST_OK,        32'sd0, 8'd1}},
        '{OP_APPEND,  32'sh7FFF_FFFF,      8'd0,   1'b1, '{ST_OK,        32'sd0, 8'd2}},
        '{OP_APPEND,  -32'sd1,             8'd255, 1'b1, '{ST_OK,        32'sd0, 8'd3}},
        '{OP_INSERT,  32'sd9,              8'd255, 1'b1, '{ST_BAD_INDEX, 32'sd0, 8'd3}},
        '{OP_INSERT,  32'sh5555_5555,      8'd1,   1'b1, '{ST_OK,        32'sd0, 8'd4}},
        '{OP_INSERT,  32'sh2AAA_AAAA,      8'd4,   1'b1, '{ST_OK,        32'sd0, 8'd5}},
        '{OP_READ,    32'sd0,              8'd0,   1'b0, '{ST_OK,        32'sd0, 8'd0}},
        '{OP_READ,    32'sd0,              8'd4,   1'b0, '{ST_OK,        32'sd0, 8'd0}},
        '{OP_READ,    32'sd0,              8'd5,   1'b1, '{ST_BAD_INDEX, 32'sd0, 8'd5}},
        '{OP_READ,    32'sd0,              8'd255, 1'b1, '{ST_BAD_INDEX, 32'sd0, 8'd5}},
        '{OP_SPARE_5, -32'sd1,             8'd255, 1'b1, '{ST_OK,        32'sd0, 8'd5}},
        '{OP_SPARE_6, 32'sh7FFF_FFFF,      8'd0,   1'b1, '{ST_OK,        32'sd0, 8'd5}},
        '{OP_SPARE_7, 32'sh8000_0000,      8'd128, 1'b1, '{ST_OK,        32'sd0, 8'd5}},
        '{OP_APPEND,  -32'sd1,             8'd0,   1'b1, '{ST_OK,        32'sd0, 8'd6}},
        '{OP_REM_VAL, -32'sd1,             8'd0,   1'b0, '{ST_OK,        32'sd0, 8'd0}},
        '{OP_READ,    32'sd0,              8'd4,   1'b0, '{ST_OK,        32'sd0, 8'd0}},
        '{OP_REM_VAL, 32'sd12345,          8'd0,   1'b1, '{ST_NOT_FOUND, 32'sd0, 8'd5}},
        '{OP_REM_IDX, 32'sd0,              8'd5,   1'b1, '{ST_BAD_INDEX, 32'sd0, 8'd5}},
        '{OP_REM_IDX, 32'sd0,              8'd128, 1'b1, '{ST_BAD_INDEX, 32'sd0, 8'd5}},
        '{OP_REM_IDX, 32'sd0,              8'd0,   1'b0, '{ST_OK,        32'sd0, 8'd0}},
        '{OP_READ,    32'sd0,              8'd0,   1'b0, '{ST_OK,        32'sd0, 8'd0}}
    };

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      in_valid   = 1'b0;
    logic                      in_ready;
    logic [OPCODE_W-1:0]       opcode     = '0;
    logic signed [VALUE_W-1:0] value      = '0;
    logic [INDEX_W-1:0]        index      = '0;
    logic                      out_valid;
    logic                      out_ready  = 1'b0;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] read_value;
    logic [COUNT_NOW_W-1:0]    count_now;

    // local copy of the list
    logic signed [VALUE_W-1:0] list_mem [CAPACITY];
    int                        list_len = 0;

    list_result_t awaited_results [$];
    int           mismatches   = 0;
    int           results_seen = 0;
    int           quiet_cycles = 0;
    bit           calm         = 1'b0;

    array_list_insert_remove_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .value      (value),
        .index      (index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .read_value (read_value),
        .count_now  (count_now)
    );

    always #2 clk = ~clk;

    function automatic void close_gap(input int pos);
        int k;
        for (k = pos; k + 1 < list_len; k++)
            list_mem[k] = list_mem[k + 1];
        list_len--;
    endfunction

    function automatic list_result_t list_apply(input logic [OPCODE_W-1:0] op,
                                                input logic signed [VALUE_W-1:0] val,
                                                input logic [INDEX_W-1:0] idx);
        list_result_t r;
        int           pos;
        int           hit;
        r.status     = ST_OK;
        r.read_value = '0;
        case (op)
            OP_APPEND:
                if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    list_mem[list_len] = val;
                    list_len++;
                end
            OP_INSERT:
                if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else if (int'(idx) > list_len)
                    r.status = ST_BAD_INDEX;
                else
                begin
                    for (pos = list_len; pos > int'(idx); pos--)
                        list_mem[pos] = list_mem[pos - 1];
                    list_mem[idx] = val;
                    list_len++;
                end
            OP_REM_VAL:
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    hit = -1;
                    for (pos = list_len - 1; pos >= 0; pos--)
                        if (list_mem[pos] == val)
                            hit = pos;
                    if (hit < 0)
                        r.status = ST_NOT_FOUND;
                    else
                        close_gap(hit);
                end
            OP_REM_IDX:
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else if (int'(idx) >= list_len)
                    r.status = ST_BAD_INDEX;
                else
                    close_gap(int'(idx));
            OP_READ:
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else if (int'(idx) >= list_len)
                    r.status = ST_BAD_INDEX;
                else
                    r.read_value = list_mem[idx];
            default: ;
        endcase
        r.count_now = list_len[COUNT_NOW_W-1:0];
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // Offer one transaction, hold it until accepted, then log its expected result.
    task automatic offer_request(input logic [OPCODE_W-1:0] op,
                                 input logic signed [VALUE_W-1:0] val,
                                 input logic [INDEX_W-1:0] idx,
                                 input logic typed, input list_result_t typed_res);
        list_result_t predicted;
        while (!calm && $urandom_range(0, 99) < 30)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        value    <= val;
        index    <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = list_apply(op, val, idx);
        awaited_results.push_back(typed ? typed_res : predicted);
    endtask

    // result checker
    always @(posedge clk)
    begin : result_check
        list_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen <= results_seen + 1;
            if (awaited_results.size() == 0)
                report("unexpected result", {29'd0, status}, '0);
            else
            begin
                want = awaited_results.pop_front();
                if (status !== want.status)
                    report("status", {29'd0, status}, {29'd0, want.status});
                if (read_value !== want.read_value)
                    report("read_value", read_value, want.read_value);
                if (count_now !== want.count_now)
                    report("count_now", {24'd0, count_now}, {24'd0, want.count_now});
            end
        end
    end

    // receiver: random back-pressure plus one long hold-off
    initial
    begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            else
                out_ready <= !(!calm && $urandom_range(0, 99) < 30);
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        int                        row;
        int                        n;
        int                        roll;
        int                        edge_rounds;
        bit                        grow;
        logic [OPCODE_W-1:0]       op;
        logic signed [VALUE_W-1:0] val;
        logic [INDEX_W-1:0]        idx;

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < N_DIRECTED; row++)
            offer_request(DIRECTED[row].op, DIRECTED[row].val, DIRECTED[row].idx,
                          DIRECTED[row].typed, DIRECTED[row].want);

        grow        = 1'b1;
        edge_rounds = 0;
        n           = 0;
        while (n < RANDOM_ITEMS)
        begin
            calm = (n >= 400 && n < 600);
            roll = $urandom_range(0, 99);
            if (roll < 4)
            begin
                case ($urandom_range(0, 2))
                    0:       op = OP_SPARE_5;
                    1:       op = OP_SPARE_6;
                    default: op = OP_SPARE_7;
                endcase
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (grow)
                    op = (roll < 40) ? OP_APPEND : (roll < 70) ? OP_INSERT :
                         (roll < 80) ? OP_REM_VAL : (roll < 90) ? OP_REM_IDX : OP_READ;
                else
                    op = (roll < 10) ? OP_APPEND : (roll < 20) ? OP_INSERT :
                         (roll < 50) ? OP_REM_VAL : (roll < 80) ? OP_REM_IDX : OP_READ;
            end

            // values: mostly full-range, some small to make duplicates, and
            // removals mostly aim at an entry that is present
            val = $urandom;
            if (op == OP_REM_VAL && list_len > 0 && $urandom_range(0, 99) < 70)
                val = list_mem[$urandom_range(0, list_len - 1)];
            else if ($urandom_range(0, 99) < 20)
                val = $urandom_range(0, 3);

            if ($urandom_range(0, 99) < 15)
                idx = INDEX_W'($urandom_range(0, 255));
            else
                idx = INDEX_W'($urandom_range(0, list_len));

            offer_request(op, val, idx, 1'b0, '0);
            if (op <= OP_READ)
                n++;

            // swing between a full list and an empty one
            if (grow && list_len == CAPACITY && ++edge_rounds > 12)
            begin
                grow        = 1'b0;
                edge_rounds = 0;
            end
            else if (!grow && list_len == 0 && ++edge_rounds > 6)
            begin
                grow        = 1'b1;
                edge_rounds = 0;
            end

            if (n == PAUSE_AT)
            begin
                in_valid <= 1'b0;
                while (awaited_results.size() != 0)
                    @(posedge clk);
            end
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
